// File: hdl/ccts_pkg.sv
// ccts_pkg: shared types, token kind codes and character class functions
// for the character class token splitter and its checker
// no dependencies
package ccts_pkg;

  localparam int CHAR_W = 8;
  localparam int KIND_W = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // token kinds as they appear on the result stream
  localparam logic [KIND_W-1:0] KIND_LPAREN  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_RPAREN  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_LBRACK  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_RBRACK  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_LBRACE  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_RBRACE  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_SEMI    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 4'd8;
  localparam logic [KIND_W-1:0] KIND_SMALL   = 4'd9;
  localparam logic [KIND_W-1:0] KIND_CAPITAL = 4'd10;
  localparam logic [KIND_W-1:0] KIND_SYMBOL  = 4'd11;
  localparam logic [KIND_W-1:0] KIND_NONE    = 4'd15;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_UNDER = 8'h5F;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] chr;
    logic              has_char;
    logic              starts_token;
    logic              ends_token;
    logic              last_of_run;
  } result_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_lower(input logic [CHAR_W-1:0] c);
    return (c >= "a") && (c <= "z");
  endfunction

  function automatic logic is_upper(input logic [CHAR_W-1:0] c);
    return (c >= "A") && (c <= "Z");
  endfunction

  function automatic logic is_symbol(input logic [CHAR_W-1:0] c);
    logic hit;
    hit = 1'b0;
    case (c) inside
      "!", "$", "%", "&", "-", "=", "~", "^", "|",
      "@", "+", ":", "*", "<", ">", "/", ".", "?": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // kind of a one-character token, KIND_NONE when c is not one
  function automatic logic [KIND_W-1:0] punct_kind(input logic [CHAR_W-1:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "[":     k = KIND_LBRACK;
      "]":     k = KIND_RBRACK;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ",":     k = KIND_COMMA;
      ";":     k = KIND_SEMI;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// File: hdl/char_class_token_splitter.sv
// char_class_token_splitter: one source byte per request, token characters
// and closing marks out through a four-entry result queue
// depends on ccts_pkg
//
// throughput: one byte per cycle while s_tready is high; a byte that
// both closes a run and starts a token gives two results, so the output
// side then sets the pace
// s_tready is high while the result queue has room for two results
// reset: synchronous, clears the open token kind and empties the queue
module char_class_token_splitter
  import ccts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_value
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] token_kind, [11:4] token_char,
                                 // [12] has_char, [13] starts_token,
                                 // [14] ends_token, [15] zero
  output logic        m_tlast    // last_of_run
);

  typedef enum logic [2:0] {
    OPEN_IDLE  = 3'd0,
    OPEN_NUM   = 3'd1,
    OPEN_SMALL = 3'd2,
    OPEN_CAP   = 3'd3,
    OPEN_SYM   = 3'd4
  } open_t;

  open_t open_kind, open_kind_next;

  result_t             queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  result_t             res0, res1, fresh, closing;
  logic                fresh_valid, is_open, cont;
  logic [1:0]          n_res;
  logic [KIND_W-1:0]   open_code, pk;
  open_t               fresh_open;
  logic                in_fire, out_fire;
  logic [CHAR_W-1:0]   c;

  assign c        = s_tdata;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign s_tready = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign m_tvalid = (count != '0);

  always_comb begin
    is_open   = 1'b1;
    open_code = KIND_NONE;
    cont      = 1'b0;
    case (open_kind)
      OPEN_NUM: begin
        open_code = KIND_NUMBER;
        cont      = is_digit(c);
      end
      OPEN_SMALL: begin
        open_code = KIND_SMALL;
        cont      = is_lower(c) || is_digit(c) || (c == CHAR_UNDER);
      end
      OPEN_CAP: begin
        open_code = KIND_CAPITAL;
        cont      = is_upper(c) || is_lower(c) || is_digit(c);
      end
      OPEN_SYM: begin
        open_code = KIND_SYMBOL;
        cont      = is_symbol(c);
      end
      default: begin
        is_open = 1'b0;
      end
    endcase
  end

  // classification of the byte as the first character of a token
  always_comb begin
    pk          = punct_kind(c);
    fresh_open  = OPEN_IDLE;
    fresh_valid = 1'b1;
    fresh       = '{kind: pk, chr: c, has_char: 1'b1, starts_token: 1'b1,
                    ends_token: 1'b1, last_of_run: 1'b0};
    if (pk == KIND_NONE) begin
      fresh.ends_token = 1'b0;
      if (is_digit(c)) begin
        fresh_open = OPEN_NUM;
        fresh.kind = KIND_NUMBER;
      end else if (is_lower(c)) begin
        fresh_open = OPEN_SMALL;
        fresh.kind = KIND_SMALL;
      end else if (is_upper(c)) begin
        fresh_open = OPEN_CAP;
        fresh.kind = KIND_CAPITAL;
      end else if (is_symbol(c)) begin
        fresh_open = OPEN_SYM;
        fresh.kind = KIND_SYMBOL;
      end else begin
        fresh_valid = 1'b0;
      end
    end
  end

  always_comb begin
    closing = '{kind: open_code, chr: CHAR_NUL, has_char: 1'b0, starts_token: 1'b0,
                ends_token: 1'b1, last_of_run: 1'b0};
    res0           = closing;
    res1           = fresh;
    n_res          = 2'd0;
    open_kind_next = OPEN_IDLE;
    if (s_tlast || (c == CHAR_NUL)) begin
      n_res = {1'b0, is_open};
    end else if (is_open && cont) begin
      res0 = '{kind: open_code, chr: c, has_char: 1'b1, starts_token: 1'b0,
               ends_token: 1'b0, last_of_run: 1'b0};
      n_res          = 2'd1;
      open_kind_next = open_kind;
    end else begin
      open_kind_next = fresh_open;
      if (is_open) begin
        n_res = 2'd1 + {1'b0, fresh_valid};
      end else begin
        res0  = fresh;
        n_res = {1'b0, fresh_valid};
      end
    end
    if (n_res == 2'd2) begin
      res1.last_of_run = 1'b1;
    end else begin
      res0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_kind <= OPEN_IDLE;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
    end else begin
      if (in_fire) begin
        open_kind <= open_kind_next;
        wr_ptr    <= wr_ptr + QPTR_W'(n_res);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (in_fire ? QCNT_W'(n_res) : '0) - QCNT_W'(out_fire);
    end
  end

  // queue payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire && (n_res != 2'd0)) begin
      queue[wr_ptr] <= res0;
    end
    if (in_fire && (n_res == 2'd2)) begin
      queue[wr_ptr + QPTR_W'(1)] <= res1;
    end
  end

  result_t head;
  assign head    = queue[rd_ptr];
  assign m_tdata = {1'b0, head.ends_token, head.starts_token, head.has_char,
                    head.chr, head.kind};
  assign m_tlast = head.last_of_run;

endmodule

// File: hdl/ccts_checker.sv
// ccts_checker: port-level assertions for char_class_token_splitter
// depends on ccts_pkg; bound to char_class_token_splitter below
module ccts_checker
  import ccts_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // the result queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] <= KIND_SYMBOL)
    else $error("token kind out of range");

  // a closing result carries no character and never starts a token
  a_close_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[12] |->
      m_tdata[14] && !m_tdata[13] && (m_tdata[11:4] == CHAR_NUL))
    else $error("malformed closing result");

  // one-character tokens open and close in the same result
  a_punct_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13] && (m_tdata[3:0] < KIND_NUMBER) |-> m_tdata[14] && m_tlast)
    else $error("punctuation token not closed at once");

endmodule

bind char_class_token_splitter ccts_checker u_ccts_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: test/ccts_token_checker.sv
// ccts_token_checker: watches both streams of the token splitter, predicts
// the token results of every accepted request and compares them in order
// depends on ccts_pkg
module ccts_token_checker
  import ccts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_value
  input  logic        s_tlast,   // end_of_input
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [3:0] token_kind, [11:4] token_char,
                                 // [12] has_char, [13] starts_token,
                                 // [14] ends_token, [15] zero
  input  logic        m_tlast,   // last_of_run
  input  logic        drain_check,
  output int          fails,
  output int          pending
);

  localparam string SYMBOL_SET = "!$%&-=~^|@+:*<>/?.";
  localparam string PUNCT_SET  = "()[]{},;";
  localparam int    MAX_PRINTS = 20;

  typedef enum logic [2:0] {
    RUN_IDLE, RUN_NUMBER, RUN_SMALL, RUN_CAPITAL, RUN_SYMBOL
  } open_run_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] chr;
    logic              has_char;
    logic              starts_tok;
    logic              ends_tok;
    logic              last;
  } tok_res_t;

  open_run_t open_run;
  tok_res_t  token_q[$];
  int        fail_count = 0;
  bit        drained = 1'b0;

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("mismatch %0d at %0t: %s", fail_count, $realtime, msg);
  endtask

  function automatic bit in_range(input logic [7:0] c, input logic [7:0] lo,
                                  input logic [7:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  // position of c in set, -1 when absent
  function automatic int set_slot(input string set, input logic [7:0] c);
    int i;
    for (i = 0; i < set.len(); i++)
      if (set[i] == c) return i;
    return -1;
  endfunction

  function automatic logic [KIND_W-1:0] run_kind(input open_run_t r);
    case (r)
      RUN_NUMBER:  return KIND_NUMBER;
      RUN_SMALL:   return KIND_SMALL;
      RUN_CAPITAL: return KIND_CAPITAL;
      default:     return KIND_SYMBOL;
    endcase
  endfunction

  function automatic bit extends_run(input open_run_t r, input logic [7:0] c);
    bit dig;
    dig = in_range(c, "0", "9");
    case (r)
      RUN_NUMBER:  return dig;
      RUN_SMALL:   return dig || in_range(c, "a", "z") || c == "_";
      RUN_CAPITAL: return dig || in_range(c, "a", "z") || in_range(c, "A", "Z");
      RUN_SYMBOL:  return set_slot(SYMBOL_SET, c) >= 0;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic tok_res_t mk_res(input logic [KIND_W-1:0] kind,
                                      input logic [7:0] chr, input logic has,
                                      input logic st, input logic en);
    tok_res_t r;
    r.kind       = kind;
    r.chr        = chr;
    r.has_char   = has;
    r.starts_tok = st;
    r.ends_tok   = en;
    r.last       = 1'b0;
    return r;
  endfunction

  // works out the results of one request and advances the open run
  function automatic void predict_tokens(input logic [7:0] c, input logic eoi);
    tok_res_t  res[$];
    open_run_t nxt;
    int        slot;
    nxt = RUN_IDLE;
    if (eoi || c == CHAR_NUL) begin
      if (open_run != RUN_IDLE)
        res = {res, mk_res(run_kind(open_run), 8'h00, 1'b0, 1'b0, 1'b1)};
    end else if (open_run != RUN_IDLE && extends_run(open_run, c)) begin
      res = {res, mk_res(run_kind(open_run), c, 1'b1, 1'b0, 1'b0)};
      nxt = open_run;
    end else begin
      if (open_run != RUN_IDLE)
        res = {res, mk_res(run_kind(open_run), 8'h00, 1'b0, 1'b0, 1'b1)};
      slot = set_slot(PUNCT_SET, c);
      if (slot >= 0) begin
        res = {res, mk_res(KIND_LPAREN + slot[KIND_W-1:0], c, 1'b1, 1'b1, 1'b1)};
      end else begin
        if (in_range(c, "0", "9")) nxt = RUN_NUMBER;
        else if (in_range(c, "a", "z")) nxt = RUN_SMALL;
        else if (in_range(c, "A", "Z")) nxt = RUN_CAPITAL;
        else if (set_slot(SYMBOL_SET, c) >= 0) nxt = RUN_SYMBOL;
        if (nxt != RUN_IDLE) res = {res, mk_res(run_kind(nxt), c, 1'b1, 1'b1, 1'b0)};
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    token_q = {token_q, res};
    open_run = nxt;
  endfunction

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    tok_res_t want;
    if (rst) begin
      open_run = RUN_IDLE;
      token_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (token_q.size() == 0) begin
          report($sformatf("result %h with nothing expected", m_tdata));
        end else begin
          want = token_q.pop_front();
          check_field("token_kind", 8'(m_tdata[3:0]), 8'(want.kind));
          check_field("token_char", m_tdata[11:4], want.chr);
          check_field("has_char", 8'(m_tdata[12]), 8'(want.has_char));
          check_field("starts_token", 8'(m_tdata[13]), 8'(want.starts_tok));
          check_field("ends_token", 8'(m_tdata[14]), 8'(want.ends_tok));
          check_field("padding", 8'(m_tdata[15]), 8'h00);
          check_field("last_of_run", 8'(m_tlast), 8'(want.last));
        end
      end
      if (s_tvalid && s_tready) predict_tokens(s_tdata, s_tlast);
      if (drain_check && !drained) begin
        drained = 1'b1;
        while (token_q.size() > 0) begin
          want = token_q.pop_front();
          report($sformatf("result kind %0d char %0h never came", want.kind, want.chr));
        end
      end
    end
    pending <= token_q.size();
    fails   <= fail_count;
  end

endmodule

// File: test/tb_char_class_token_splitter.sv
// tb_char_class_token_splitter: feeds source bytes to the token splitter
// under several idling phases and gives the verdict from the checker
// depends on ccts_pkg, char_class_token_splitter and ccts_token_checker
module tb_char_class_token_splitter
  import ccts_pkg::*;
;

  localparam int    PHASE_ITEMS = 380;
  localparam int    NUM_PHASES  = 5;
  localparam int    HOLD_CYCLES = 400;
  localparam int    QUIET_LIMIT = 2000;
  localparam int    TAIL_CYCLES = 10;
  localparam string SYMBOL_SET  = "!$%&-=~^|@+:*<>/?.";
  localparam string PUNCT_SET   = "()[]{},;";
  localparam string SPACE_SET   = " \t\n\r";
  localparam string DIRECTED    = "(az_9)[0]{Zz9}!?,~;";

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] char_value
  logic        s_tlast;   // end_of_input
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [3:0] token_kind, [11:4] token_char, [12] has_char,
                          // [13] starts_token, [14] ends_token, [15] zero
  logic        m_tlast;   // last_of_run
  logic        drain_check;
  int          fails;
  int          pending;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent           = 0;
  bit hold_req       = 1'b0;
  bit hold_done      = 1'b0;

  char_class_token_splitter u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  ccts_token_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .drain_check(drain_check), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // returns at the edge where the request is taken
  task automatic send_byte(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eoi;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  function automatic logic [7:0] pick_from(input string set);
    return set[$urandom_range(set.len() - 1, 0)];
  endfunction

  function automatic logic [7:0] pick_span(input logic [7:0] lo, input int n);
    return lo + 8'($urandom_range(n - 1, 0));
  endfunction

  // one well-formed token with random content, or a piece of noise
  task automatic send_random_chunk();
    int sel;
    int len;
    int i;
    int mix;
    sel = $urandom_range(99, 0);
    len = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 1) : $urandom_range(4, 1);
    if (sel < 14) begin
      for (i = 0; i < len; i++) send_byte(pick_span("0", 10), 1'b0);
    end else if (sel < 32) begin
      send_byte(pick_span("a", 26), 1'b0);
      for (i = 1; i < len; i++) begin
        mix = $urandom_range(3, 0);
        send_byte(mix == 0 ? pick_span("0", 10) : mix == 1 ? CHAR_UNDER
                  : pick_span("a", 26), 1'b0);
      end
    end else if (sel < 48) begin
      send_byte(pick_span("A", 26), 1'b0);
      for (i = 1; i < len; i++) begin
        mix = $urandom_range(2, 0);
        send_byte(mix == 0 ? pick_span("0", 10) : mix == 1 ? pick_span("a", 26)
                  : pick_span("A", 26), 1'b0);
      end
    end else if (sel < 60) begin
      for (i = 0; i < len; i++) send_byte(pick_from(SYMBOL_SET), 1'b0);
    end else if (sel < 75) begin
      send_byte(pick_from(PUNCT_SET), 1'b0);
    end else if (sel < 84) begin
      send_byte(pick_from(SPACE_SET), 1'b0);
    end else if (sel < 95) begin
      send_byte(8'($urandom_range(255, 0)), 1'b0);
    end else if (sel < 98) begin
      send_byte(CHAR_NUL, 1'b0);
    end else begin
      send_byte(8'($urandom_range(255, 0)), 1'b1);
    end
  endtask

  initial begin : result_sink
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int i;
    int ph;
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= 8'h00;
    s_tlast     <= 1'b0;
    drain_check <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // punctuation, each run kind, and runs closed by punctuation
    for (i = 0; i < DIRECTED.len(); i++) send_byte(DIRECTED[i], 1'b0);
    send_byte(CHAR_UNDER, 1'b0);   // underscore with no run open is skipped
    send_byte("Q", 1'b0);
    send_byte(CHAR_NUL, 1'b0);     // nul closes the run
    send_byte(CHAR_NUL, 1'b0);     // nul with nothing open
    send_byte("7", 1'b0);
    send_byte("x", 1'b1);          // end flag closes, byte ignored
    send_byte(8'hFF, 1'b1);        // end flag with nothing open
    send_byte("+", 1'b0);
    send_byte(8'hFF, 1'b0);        // high byte closes and is skipped
    send_byte(8'h80, 1'b0);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
        3:       begin send_idle_pct = 18; recv_stall_pct = 18; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      // last phase: sink holds off while the source keeps offering
      if (ph == NUM_PHASES - 1) hold_req = 1'b1;
      while (sent < (ph + 1) * PHASE_ITEMS) send_random_chunk();
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    drain_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
